// ===== design/idll_pkg.sv =====
// Package for the indexed doubly linked list: sizes, link codes, FSM states
// and the structs passed between the core, the link RAMs and the top level.
// No dependencies.
package idll_pkg;

	// Table size and derived widths
	localparam int ENTRIES = 8192;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int LINK_W  = 14;
	localparam int ELEM_W  = 13;
	localparam int CNT_W   = 14;

	// Link value that means "no element"
	localparam logic [LINK_W-1:0] LINK_NONE = '1;

	// Request kinds carried in tuser
	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_UNLINK = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SECOND
	} state_t;

	// Command for one link RAM: one write port, one read port
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [LINK_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_cmd_t;

	// One result transaction
	typedef struct packed {
		logic              error;
		logic [CNT_W-1:0]  count;
		logic [LINK_W-1:0] tail;
		logic [LINK_W-1:0] head;
	} result_t;

	// A link points at a real entry
	function automatic logic link_valid(input logic [LINK_W-1:0] v);
		return (v != LINK_NONE) && (32'(v) < ENTRIES);
	endfunction

endpackage

// ===== design/indexed_doubly_linked_list.sv =====
// Top level of the indexed doubly linked list: stream ports, output register,
// the list controller and the previous/next link RAMs.
// Depends on idll_pkg, idll_core, idll_ram.
//
// Channel   Dir  Payload
// s_axis    in   tdata[12:0] element; tuser[0] mode (0 append, 1 unlink)
// m_axis    out  tdata head_index, tail_index, element_count; tuser[0] error
//
// Each transaction has a first step that writes (and for unlink reads) the
// element's own links and a second step that writes the neighbor link; each
// link RAM has a single write port. After reset both link RAMs are swept to
// "none", one entry per cycle, with s_axis_tready low. A new transaction is
// taken while a result sits in the output register; the second step holds
// when that register is still full and m_axis_tready is low.
module indexed_doubly_linked_list (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [12:0] element, [15:13] zero
	input  logic [0:0]  s_axis_tuser,  // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [13:0] head_index, [27:14] tail_index,
	                                   // [41:28] element_count, [47:42] zero
	output logic [0:0]  m_axis_tuser   // [0] error
);

	logic                               res_valid;
	logic                               res_ready;
	idll_pkg::result_t                  res;
	idll_pkg::result_t                  out_q;
	logic                               out_valid_q;
	idll_pkg::ram_cmd_t                 prev_cmd, next_cmd;
	logic [idll_pkg::LINK_W-1:0]        prev_rdata, next_rdata;

	assign res_ready = !out_valid_q || m_axis_tready;

	idll_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_axis_tvalid),
		.req_ready   (s_axis_tready),
		.req_mode    (s_axis_tuser[0]),
		.req_element (s_axis_tdata[idll_pkg::ELEM_W-1:0]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.prev_cmd    (prev_cmd),
		.next_cmd    (next_cmd),
		.prev_rdata  (prev_rdata),
		.next_rdata  (next_rdata)
	);

	idll_ram #(
		.WIDTH (idll_pkg::LINK_W),
		.DEPTH (idll_pkg::ENTRIES)
	) u_prev_ram (
		.clk   (clk),
		.we    (prev_cmd.we),
		.waddr (prev_cmd.waddr),
		.wdata (prev_cmd.wdata),
		.re    (prev_cmd.re),
		.raddr (prev_cmd.raddr),
		.rdata (prev_rdata)
	);

	idll_ram #(
		.WIDTH (idll_pkg::LINK_W),
		.DEPTH (idll_pkg::ENTRIES)
	) u_next_ram (
		.clk   (clk),
		.we    (next_cmd.we),
		.waddr (next_cmd.waddr),
		.wdata (next_cmd.wdata),
		.re    (next_cmd.re),
		.raddr (next_cmd.raddr),
		.rdata (next_rdata)
	);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {6'd0, out_q.count, out_q.tail, out_q.head};
	assign m_axis_tuser[0] = out_q.error;

endmodule

// ===== design/idll_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Read-first: a read of the address being written returns the old word.
// No dependencies.
module idll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/idll_core.sv =====
// List controller: clearing pass, append/unlink sequencer,
// head/tail/count registers and the commands for both link RAMs.
// Depends on idll_pkg.
module idll_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic                             req_mode,
	input  logic [idll_pkg::ELEM_W-1:0]      req_element,
	output logic                             res_valid,
	input  logic                             res_ready,
	output idll_pkg::result_t                res,
	output idll_pkg::ram_cmd_t               prev_cmd,
	output idll_pkg::ram_cmd_t               next_cmd,
	input  logic [idll_pkg::LINK_W-1:0]      prev_rdata,
	input  logic [idll_pkg::LINK_W-1:0]      next_rdata
);

	idll_pkg::state_t                   state_q, state_d;
	logic [idll_pkg::ADDR_W-1:0]        clr_addr_q;
	logic                               mode_q;
	logic [idll_pkg::ELEM_W-1:0]        elem_q;
	logic                               err_q;
	logic [idll_pkg::LINK_W-1:0]        head_q, head_d;
	logic [idll_pkg::LINK_W-1:0]        tail_q, tail_d;
	logic [idll_pkg::CNT_W-1:0]         count_q, count_d;
	logic                               req_err;
	logic                               accept;
	logic                               finish;
	logic [idll_pkg::LINK_W-1:0]        elem_link;

	assign elem_link = idll_pkg::LINK_W'(elem_q);
	assign req_ready = (state_q == idll_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign finish    = (state_q == idll_pkg::ST_SECOND) && res_ready;

	// Ignored requests: bad index, append when full, unlink when empty
	always_comb begin
		req_err = 1'b0;
		if (32'(req_element) >= idll_pkg::ENTRIES) begin
			req_err = 1'b1;
		end else if (req_mode == idll_pkg::MODE_APPEND) begin
			req_err = (32'(count_q) >= idll_pkg::ENTRIES);
		end else begin
			req_err = (count_q == '0);
		end
	end

	// Next state, RAM commands and list registers
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		res_valid = 1'b0;
		prev_cmd  = '0;
		next_cmd  = '0;
		case (state_q)
			idll_pkg::ST_CLEAR: begin
				prev_cmd.we    = 1'b1;
				prev_cmd.waddr = clr_addr_q;
				prev_cmd.wdata = idll_pkg::LINK_NONE;
				next_cmd.we    = 1'b1;
				next_cmd.waddr = clr_addr_q;
				next_cmd.wdata = idll_pkg::LINK_NONE;
				if (32'(clr_addr_q) == idll_pkg::ENTRIES - 1) begin
					state_d = idll_pkg::ST_IDLE;
				end
			end
			idll_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = idll_pkg::ST_SECOND;
					if (!req_err) begin
						// Own links of the element; unlink reads the old ones first
						prev_cmd.we    = 1'b1;
						prev_cmd.waddr = idll_pkg::ADDR_W'(req_element);
						next_cmd.we    = 1'b1;
						next_cmd.waddr = idll_pkg::ADDR_W'(req_element);
						next_cmd.wdata = idll_pkg::LINK_NONE;
						if (req_mode == idll_pkg::MODE_APPEND) begin
							prev_cmd.wdata = (count_q == '0) ? idll_pkg::LINK_NONE : tail_q;
						end else begin
							prev_cmd.wdata = idll_pkg::LINK_NONE;
							prev_cmd.re    = 1'b1;
							prev_cmd.raddr = idll_pkg::ADDR_W'(req_element);
							next_cmd.re    = 1'b1;
							next_cmd.raddr = idll_pkg::ADDR_W'(req_element);
						end
					end
				end
			end
			idll_pkg::ST_SECOND: begin
				if (finish) begin
					res_valid = 1'b1;
					state_d   = idll_pkg::ST_IDLE;
					if (!err_q) begin
						if (mode_q == idll_pkg::MODE_APPEND) begin
							// Hook the old tail to the new element
							if (count_q != '0 && idll_pkg::link_valid(tail_q)) begin
								next_cmd.we    = 1'b1;
								next_cmd.waddr = idll_pkg::ADDR_W'(tail_q);
								next_cmd.wdata = elem_link;
							end
							if (count_q == '0) begin
								head_d = elem_link;
							end
							tail_d  = elem_link;
							count_d = count_q + 1'b1;
						end else begin
							// Patch neighbors; a self link was already cleared
							if (idll_pkg::link_valid(prev_rdata)) begin
								if (prev_rdata != elem_link) begin
									next_cmd.we    = 1'b1;
									next_cmd.waddr = idll_pkg::ADDR_W'(prev_rdata);
									next_cmd.wdata = next_rdata;
								end
							end else begin
								head_d = next_rdata;
							end
							if (idll_pkg::link_valid(next_rdata)) begin
								if (next_rdata != elem_link) begin
									prev_cmd.we    = 1'b1;
									prev_cmd.waddr = idll_pkg::ADDR_W'(next_rdata);
									prev_cmd.wdata = prev_rdata;
								end
							end else begin
								tail_d = prev_rdata;
							end
							count_d = count_q - 1'b1;
						end
					end
				end
			end
			default: begin
				state_d = idll_pkg::ST_IDLE;
			end
		endcase
	end

	assign res.head  = head_d;
	assign res.tail  = tail_d;
	assign res.count = count_d;
	assign res.error = err_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= idll_pkg::ST_CLEAR;
			clr_addr_q <= '0;
			head_q     <= idll_pkg::LINK_NONE;
			tail_q     <= idll_pkg::LINK_NONE;
			count_q    <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			if (state_q == idll_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Request held for the ST_SECOND state
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req_mode;
			elem_q <= req_element;
			err_q  <= req_err;
		end
	end

endmodule
